// File: sv/windowed_threshold_duty_regulator_core_macros.svh
// Assertion macros for the duty regulator core.
// Included by the modules that carry concurrent assertions; needs a clk and rst in scope.
`ifndef WINDOWED_THRESHOLD_DUTY_REGULATOR_CORE_MACROS_SVH
`define WINDOWED_THRESHOLD_DUTY_REGULATOR_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WTDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WTDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/wtdr_pkg.sv
// Shared types and constants for the windowed threshold duty regulator.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package wtdr_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int COUNT_BITS    = 20;
  localparam int BAL_BITS      = COUNT_BITS + 1;
  localparam int DUTY_BITS     = 10;
  localparam int GAIN_BITS     = 16;
  localparam int DUTY_MAX      = 1023;
  localparam int CFG_DATA_BITS = 20;
  localparam int CFG_IDX_BITS  = 3;
  // Product of duty in Q.16 plus balance times gain, with room for the sign.
  localparam int TOTAL_BITS    = BAL_BITS + GAIN_BITS + 1;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic signed [BAL_BITS-1:0] balance_t;
  typedef logic [DUTY_BITS-1:0]     duty_t;
  typedef logic [GAIN_BITS-1:0]     gain_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_WINDOW_LENGTH   = 3'd1,
    REG_LOOP_GAIN       = 3'd2,
    REG_START_DUTY      = 3'd3
  } cfg_reg_t;

  localparam sample_t RESET_LEVEL_THRESHOLD = 10'd400;
  localparam count_t  RESET_WINDOW_LENGTH   = 20'd300000;
  localparam gain_t   RESET_LOOP_GAIN       = 16'd66;
  localparam duty_t   RESET_START_DUTY      = 10'd511;

endpackage

`default_nettype wire

// File: sv/wtdr_ifs.sv
// Valid/ready channel interfaces for converter samples and duty results.
// Depends on wtdr_pkg for the payload types.
`default_nettype none

interface wtdr_sample_if;
  import wtdr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface wtdr_result_if;
  import wtdr_pkg::*;

  logic     valid;
  logic     ready;
  duty_t    duty_value;
  logic [7:0] duty_upper;
  logic [1:0] duty_lower;
  balance_t window_balance;

  modport source (output valid, output duty_value, output duty_upper, output duty_lower,
                  output window_balance, input ready);
  modport sink (input valid, input duty_value, input duty_upper, input duty_lower,
                input window_balance, output ready);
endinterface

`default_nettype wire

// File: sv/windowed_threshold_duty_regulator_core.sv
// Top level of the windowed threshold duty regulator: sample register, window logic, result register.
// Depends on wtdr_pkg, the channel interfaces in wtdr_ifs.sv and the assertion macro header.
//
// Each accepted converter sample is compared with level_threshold and moves a signed balance
// up or down by one. After window_length samples (zero counts as one) the duty becomes
// floor(duty + balance * loop_gain / 65536), clamped to 0..1023, and one result item carries
// the new duty, its top eight and low two bits, and the finished window's balance. Other
// samples produce no result. An accepted item passes through the sample register, then the
// balance update, the 21 x 17 multiply and the clamp into the result register. A new sample
// is accepted every cycle; the only stall is a window end while the previous result still
// waits downstream. Writing start_duty also loads the duty at once. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "windowed_threshold_duty_regulator_core_macros.svh"

module windowed_threshold_duty_regulator_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [wtdr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire wtdr_pkg::cfg_data_t              cfg_data,
  wtdr_sample_if.sink                           samples,
  wtdr_result_if.source                         results
);
  import wtdr_pkg::*;

  // Configuration registers.
  sample_t level_threshold;
  count_t  window_length;
  gain_t   loop_gain;

  // Window state.
  balance_t balance_count;
  count_t   samples_seen;
  duty_t    duty_level;

  // Sample register.
  logic    s1_valid;
  sample_t s1_sample;

  // Result register.
  logic     out_valid;
  duty_t    out_duty;
  balance_t out_balance;

  balance_t                      balance_next;
  count_t                        seen_next;
  count_t                        win_len;
  logic                          win_end;
  logic                          advance;
  logic signed [TOTAL_BITS-1:0] bal_ext;
  logic signed [TOTAL_BITS-1:0] gain_ext;
  logic signed [TOTAL_BITS-1:0] duty_q;
  logic signed [TOTAL_BITS-1:0] total;
  duty_t                         duty_new;

  always_comb begin
    balance_next = (s1_sample > level_threshold) ? balance_count + BAL_BITS'(1)
                                                 : balance_count - BAL_BITS'(1);
    seen_next    = samples_seen + COUNT_BITS'(1);
    win_len      = (window_length == '0) ? COUNT_BITS'(1) : window_length;
    // A counter that wraps to zero also closes the window.
    win_end      = (seen_next >= win_len) || (seen_next == '0);
    advance      = s1_valid && (!win_end || !out_valid || results.ready);

    bal_ext  = TOTAL_BITS'(balance_next);
    gain_ext = $signed({{(TOTAL_BITS-GAIN_BITS){1'b0}}, loop_gain});
    duty_q   = $signed({{(TOTAL_BITS-DUTY_BITS-16){1'b0}}, duty_level, 16'b0});
    total    = duty_q + bal_ext * gain_ext;

    if (total[TOTAL_BITS-1]) begin
      duty_new = '0;
    end else if (total[TOTAL_BITS-2:16] > (TOTAL_BITS-17)'(DUTY_MAX)) begin
      duty_new = DUTY_BITS'(DUTY_MAX);
    end else begin
      duty_new = total[DUTY_BITS+15:16];
    end
  end

  assign samples.ready          = !s1_valid || advance;
  assign results.valid          = out_valid;
  assign results.duty_value     = out_duty;
  assign results.duty_upper     = out_duty[DUTY_BITS-1:DUTY_BITS-8];
  assign results.duty_lower     = out_duty[1:0];
  assign results.window_balance = out_balance;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= RESET_LEVEL_THRESHOLD;
      window_length   <= RESET_WINDOW_LENGTH;
      loop_gain       <= RESET_LOOP_GAIN;
      balance_count   <= '0;
      samples_seen    <= '0;
      duty_level      <= RESET_START_DUTY;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (samples.ready) begin
        s1_valid <= samples.valid;
      end

      if (advance) begin
        if (win_end) begin
          balance_count <= '0;
          samples_seen  <= '0;
          duty_level    <= duty_new;
        end else begin
          balance_count <= balance_next;
          samples_seen  <= seen_next;
        end
      end

      if (advance && win_end) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      // User writes only while idle (unenforced); else the preset load can collide with a window end.
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LEVEL_THRESHOLD: level_threshold <= cfg_data[SAMPLE_BITS-1:0];
          REG_WINDOW_LENGTH:   window_length   <= cfg_data[COUNT_BITS-1:0];
          REG_LOOP_GAIN:       loop_gain       <= cfg_data[GAIN_BITS-1:0];
          REG_START_DUTY:      duty_level      <= cfg_data[DUTY_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_sample <= samples.adc_sample;
    end
    if (advance && win_end) begin
      out_duty    <= duty_new;
      out_balance <= balance_next;
    end
  end

  `WTDR_ASSERT_SAME(a_balance_bounded, 1'b1,
    (balance_count <= $signed({1'b0, samples_seen})) &&
    (balance_count >= -$signed({1'b0, samples_seen})),
    "balance magnitude exceeds the number of samples in the window")

  `WTDR_ASSERT_NEXT(a_window_restart, advance && win_end,
    (balance_count == '0) && (samples_seen == '0),
    "window state not cleared after a window end")

  `WTDR_ASSERT_NEXT(a_result_loaded, advance && win_end,
    out_valid && (out_balance == $past(balance_next)) && (out_duty == duty_level),
    "result register does not hold the finished window")

endmodule

`default_nettype wire
